@@ hdl/bffa_pkg.sv @@
package bffa_pkg;

  localparam int MAP_BITS_DEF  = 8192;
  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_W       = 14;
  localparam int STATUS_W      = 2;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam logic [FIELD_W-1:0] LIMIT_RESET = 14'd8192;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_REJECT = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_t;

  typedef enum logic {
    REG_ITEM_LIMIT = 1'b0,
    REG_NONE       = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ASUM,
    ST_AMAP,
    ST_FCHK
  } state_t;

  typedef struct packed {
    logic clr_we;
    logic accept;
    logic rd_map;
    logic alloc_fin;
    logic free_fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_free;
    logic out_busy;
  } ctrl_sts_t;

endpackage

@@ hdl/bitmap_first_fit_allocator_core.sv @@
// Channel  Direction  Handshake           Word
// in       input      in_valid/in_ready   in_command, in_item_number
// out      output     out_valid/out_ready out_allocated_number, out_status, out_free_count
// cfg      input      APB psel/penable    item_limit at byte address 0
//
// An allocate: summary RAM read, bitmap RAM read, then update and result.
// A free: both RAM words are read at accept, then updated with the result.
// After reset all MAP_BITS/WORD_BITS bitmap words (256 by default) and the summary
// RAM are cleared, during which in_ready stays low.
// A new word is accepted while the previous result waits; a request only finishes once
// the output register is free.
module bitmap_first_fit_allocator_core #(
  parameter int MAP_BITS  = bffa_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [bffa_pkg::FIELD_W-1:0]        in_item_number,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bffa_pkg::FIELD_W-1:0]        out_allocated_number,
  output logic [bffa_pkg::STATUS_W-1:0]       out_status,
  output logic [bffa_pkg::FIELD_W-1:0]        out_free_count,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bffa_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bffa_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [bffa_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic [bffa_pkg::FIELD_W-1:0] item_limit_r, item_limit_nxt;
  bffa_pkg::reg_index_t         reg_idx;
  bffa_pkg::ctrl_cmd_t          cmd;
  bffa_pkg::ctrl_sts_t          sts;

  assign pready  = 1'b1;
  assign reg_idx = bffa_pkg::reg_index_t'(paddr[2]);

  always_comb begin
    item_limit_nxt = item_limit_r;
    if (psel && penable && pwrite && pready && (reg_idx == bffa_pkg::REG_ITEM_LIMIT)) begin
      item_limit_nxt = pwdata[bffa_pkg::FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_limit_r <= bffa_pkg::LIMIT_RESET;
    end else begin
      item_limit_r <= item_limit_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      bffa_pkg::REG_ITEM_LIMIT: begin
        prdata = bffa_pkg::CFG_DATA_W'(item_limit_r);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  bffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bffa_dp #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_command           (in_command),
    .in_item_number       (in_item_number),
    .item_limit           (item_limit_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_allocated_number (out_allocated_number),
    .out_status           (out_status),
    .out_free_count       (out_free_count)
  );

endmodule

@@ hdl/bffa_ram.sv @@
module bffa_ram #(
  parameter int WIDTH = bffa_pkg::WORD_BITS_DEF,
  parameter int DEPTH = bffa_pkg::MAP_BITS_DEF / bffa_pkg::WORD_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bffa_ctrl.sv @@
module bffa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bffa_pkg::ctrl_sts_t   sts,
  output bffa_pkg::ctrl_cmd_t   cmd
);

  bffa_pkg::state_t state_r;
  bffa_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bffa_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bffa_pkg::ST_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = bffa_pkg::ST_IDLE;
        end
      end
      bffa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_free ? bffa_pkg::ST_FCHK : bffa_pkg::ST_ASUM;
        end
      end
      bffa_pkg::ST_ASUM: begin
        state_nxt = bffa_pkg::ST_AMAP;
      end
      bffa_pkg::ST_AMAP, bffa_pkg::ST_FCHK: begin
        if (!sts.out_busy) begin
          state_nxt = bffa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bffa_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      bffa_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      bffa_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      bffa_pkg::ST_ASUM: begin
        cmd.rd_map = 1'b1;
      end
      bffa_pkg::ST_AMAP: begin
        cmd.alloc_fin = !sts.out_busy;
      end
      bffa_pkg::ST_FCHK: begin
        cmd.free_fin = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/bffa_dp.sv @@
module bffa_dp #(
  parameter int MAP_BITS  = bffa_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bffa_pkg::ctrl_cmd_t               cmd,
  output bffa_pkg::ctrl_sts_t               sts,
  input  logic                              in_command,
  input  logic [bffa_pkg::FIELD_W-1:0]      in_item_number,
  input  logic [bffa_pkg::FIELD_W-1:0]      item_limit,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bffa_pkg::FIELD_W-1:0]      out_allocated_number,
  output logic [bffa_pkg::STATUS_W-1:0]     out_status,
  output logic [bffa_pkg::FIELD_W-1:0]      out_free_count
);

  localparam int FW        = bffa_pkg::FIELD_W;
  localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
  localparam int SUM_WORDS = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int MA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SA_W      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int WI_W      = SA_W + BIT_W;
  localparam int POS_W     = WI_W + BIT_W;

  logic [SUM_WORDS-1:0]  top_full_r, top_full_nxt;
  logic [MA_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [FW-1:0]         used_r, used_nxt;
  logic                  fail_r, fail_nxt;
  logic [SA_W-1:0]       sidx_r, sidx_nxt;
  logic [BIT_W-1:0]      sbit_r, sbit_nxt;
  logic [BIT_W-1:0]      mbit_r, mbit_nxt;
  logic [MA_W-1:0]       maddr_r, maddr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FW-1:0]         out_num_r, out_num_nxt;
  bffa_pkg::status_t     out_status_r, out_status_nxt;
  logic [FW-1:0]         out_fc_r, out_fc_nxt;

  logic [FW-1:0]         eff_lim;
  logic [SA_W-1:0]       top_idx;
  logic                  top_none;
  logic [BIT_W-1:0]      sbit_find;
  logic                  snone;
  logic [BIT_W-1:0]      mbit_find;
  logic                  mnone;
  logic [FW-1:0]         fr_pos;
  logic [FW-1:0]         fr_wfull;
  logic                  fr_bad;
  logic [WI_W-1:0]       alloc_widx;
  logic [POS_W-1:0]      alloc_pos;
  logic                  alloc_ok;
  logic                  free_ok;
  logic [WORD_BITS-1:0]  map_rdata, sum_rdata;
  logic [WORD_BITS-1:0]  map_set, sum_set, map_clr, sum_clr;
  logic                  map_we, sum_we, map_re, sum_re;
  logic [MA_W-1:0]       map_waddr, map_raddr;
  logic [SA_W-1:0]       sum_waddr, sum_raddr;
  logic [WORD_BITS-1:0]  map_wdata, sum_wdata;

  assign eff_lim = (32'(item_limit) > 32'(MAP_BITS)) ? FW'(MAP_BITS) : item_limit;

  always_comb begin
    top_idx  = '0;
    top_none = 1'b1;
    for (int i = SUM_WORDS - 1; i >= 0; i--) begin
      if (!top_full_r[i]) begin
        top_idx  = SA_W'(i);
        top_none = 1'b0;
      end
    end
  end

  always_comb begin
    sbit_find = '0;
    snone     = 1'b1;
    mbit_find = '0;
    mnone     = 1'b1;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!sum_rdata[i]) begin
        sbit_find = BIT_W'(i);
        snone     = 1'b0;
      end
      if (!map_rdata[i]) begin
        mbit_find = BIT_W'(i);
        mnone     = 1'b0;
      end
    end
  end

  assign fr_pos     = in_item_number - FW'(1);
  assign fr_wfull   = fr_pos >> BIT_W;
  assign fr_bad     = (in_item_number == '0) || (in_item_number > eff_lim);
  assign alloc_widx = {sidx_r, sbit_find};
  assign alloc_pos  = {sidx_r, sbit_r, mbit_find};
  assign alloc_ok   = !fail_r && !mnone && (32'(alloc_pos) < 32'(eff_lim));
  assign free_ok    = !fail_r && map_rdata[mbit_r];
  assign map_set    = map_rdata | (WORD_BITS'(1) << mbit_find);
  assign sum_set    = sum_rdata | (WORD_BITS'(1) << sbit_r);
  assign map_clr    = map_rdata & ~(WORD_BITS'(1) << mbit_r);
  assign sum_clr    = sum_rdata & ~(WORD_BITS'(1) << sbit_r);

  assign map_re    = cmd.accept || cmd.rd_map;
  assign map_raddr = cmd.rd_map ? alloc_widx[MA_W-1:0] : MA_W'(fr_wfull);
  assign sum_re    = cmd.accept;
  assign sum_raddr = (in_command == bffa_pkg::CMD_FREE) ? SA_W'(fr_wfull >> BIT_W) : top_idx;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = maddr_r;
    map_wdata = map_set;
    sum_we    = 1'b0;
    sum_waddr = sidx_r;
    sum_wdata = sum_set;
    if (cmd.clr_we) begin
      map_we    = 1'b1;
      map_waddr = clr_cnt_r;
      map_wdata = '0;
      sum_we    = 32'(clr_cnt_r) < 32'(SUM_WORDS);
      sum_waddr = SA_W'(clr_cnt_r);
      sum_wdata = '0;
    end else if (cmd.alloc_fin && alloc_ok) begin
      map_we = 1'b1;
      sum_we = &map_set;
    end else if (cmd.free_fin && free_ok) begin
      map_we    = 1'b1;
      map_wdata = map_clr;
      sum_we    = 1'b1;
      sum_wdata = sum_clr;
    end
  end

  always_comb begin
    fail_nxt  = fail_r;
    sidx_nxt  = sidx_r;
    sbit_nxt  = sbit_r;
    mbit_nxt  = mbit_r;
    maddr_nxt = maddr_r;
    if (cmd.accept) begin
      if (in_command == bffa_pkg::CMD_FREE) begin
        fail_nxt  = fr_bad;
        sidx_nxt  = SA_W'(fr_wfull >> BIT_W);
        sbit_nxt  = fr_wfull[BIT_W-1:0];
        mbit_nxt  = fr_pos[BIT_W-1:0];
        maddr_nxt = MA_W'(fr_wfull);
      end else begin
        fail_nxt = top_none;
        sidx_nxt = top_idx;
      end
    end else if (cmd.rd_map) begin
      sbit_nxt  = sbit_find;
      maddr_nxt = alloc_widx[MA_W-1:0];
      fail_nxt  = fail_r || snone || (32'(alloc_widx) >= 32'(MAP_WORDS));
    end
  end

  always_comb begin
    clr_cnt_nxt    = cmd.clr_we ? clr_cnt_r + MA_W'(1) : clr_cnt_r;
    top_full_nxt   = top_full_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_num_nxt    = out_num_r;
    out_status_nxt = out_status_r;
    if (cmd.alloc_fin) begin
      out_num_nxt    = '0;
      out_status_nxt = bffa_pkg::STS_FULL;
      if (alloc_ok) begin
        used_nxt       = used_r + FW'(1);
        out_num_nxt    = FW'({1'b0, alloc_pos} + (POS_W + 1)'(1));
        out_status_nxt = bffa_pkg::STS_OK;
        if ((&map_set) && (&sum_set)) begin
          top_full_nxt[sidx_r] = 1'b1;
        end
      end
    end else if (cmd.free_fin) begin
      out_num_nxt    = '0;
      out_status_nxt = bffa_pkg::STS_REJECT;
      if (free_ok) begin
        out_status_nxt       = bffa_pkg::STS_OK;
        top_full_nxt[sidx_r] = 1'b0;
        if (used_r != '0) begin
          used_nxt = used_r - FW'(1);
        end
      end
    end
    if (cmd.alloc_fin || cmd.free_fin) begin
      out_valid_nxt = 1'b1;
    end
    out_fc_nxt = (used_nxt >= eff_lim) ? '0 : eff_lim - used_nxt;
    if (!(cmd.alloc_fin || cmd.free_fin)) begin
      out_fc_nxt = out_fc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_full_r  <= '0;
      clr_cnt_r   <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_full_r  <= top_full_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fail_r       <= fail_nxt;
    sidx_r       <= sidx_nxt;
    sbit_r       <= sbit_nxt;
    mbit_r       <= mbit_nxt;
    maddr_r      <= maddr_nxt;
    out_num_r    <= out_num_nxt;
    out_status_r <= out_status_nxt;
    out_fc_r     <= out_fc_nxt;
  end

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SUM_WORDS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .re    (sum_re),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  assign sts.clr_last = (clr_cnt_r == MA_W'(MAP_WORDS - 1));
  assign sts.in_free  = (in_command == bffa_pkg::CMD_FREE);
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid            = out_valid_r;
  assign out_allocated_number = out_num_r;
  assign out_status           = out_status_r;
  assign out_free_count       = out_fc_r;

  a_no_number_on_failure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != bffa_pkg::STS_OK)) |-> (out_num_r == '0))
    else $error("Result carries a number although nothing was allocated.");

  a_free_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fc_r <= eff_lim))
    else $error("Free count exceeds the effective limit.");

  a_used_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((used_r == $past(used_r)) || (used_r == $past(used_r) + FW'(1)) ||
                      (used_r == $past(used_r) - FW'(1))))
    else $error("Used count moved by more than one.");

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.alloc_fin || cmd.free_fin) |-> (!out_valid_r || out_ready))
    else $error("Request finished while the previous word was still waiting.");

endmodule
